>>> design/hrp_pkg.sv
// Shared types, widths and arithmetic step functions for the HEALPix ring-number pipeline.
// Every other design file depends on this package.
package hrp_pkg;

  // Field widths at the block boundary.
  localparam int RES_W  = 14;
  localparam int PIX_W  = 30;
  localparam int RING_W = 15;
  localparam int REG_W  = 2;

  localparam int MAX_RESOLUTION = 8192;

  // Widths of the derived pixel counts: n*n, 12*n*n and 2*n*(n-1).
  localparam int NN_W   = 27;
  localparam int NPIX_W = 30;
  localparam int NCAP_W = 27;

  // Iteration pipeline: each stage retires a fixed number of root and quotient bits.
  localparam int ITER_STAGES     = 8;
  localparam int STEPS_PER_STAGE = 2;
  localparam int TOTAL_STEPS     = ITER_STAGES * STEPS_PER_STAGE;

  // Square root operand: the radicand is at most 28 bits, padded to two bits per step.
  localparam int SQ_IN_W   = 28;
  localparam int SQ_ARG_W  = 2 * TOTAL_STEPS;
  localparam int SQ_ROOT_W = TOTAL_STEPS;
  localparam int SQ_REM_W  = TOTAL_STEPS + 2;
  localparam int SQ_TRY_W  = SQ_REM_W + 2;

  // Division operand: (p - ncap) / 4, divided by n.
  localparam int DV_W     = 28;
  localparam int DV_LOW_W = TOTAL_STEPS;
  localparam int DV_Q_W   = TOTAL_STEPS;
  localparam int DV_REM_W = RES_W;

  // Working width of the ring sum and difference in the back end.
  localparam int RING_SUM_W = RING_W + 2;

  typedef enum logic [REG_W-1:0] {
    REGION_NORTH   = 2'd0,
    REGION_EQUATOR = 2'd1,
    REGION_SOUTH   = 2'd2
  } region_t;

  // Per-item control information that rides alongside the arithmetic.
  typedef struct packed {
    logic             err;
    region_t          region;
    logic [RES_W-1:0] n;
  } tag_t;

  typedef struct packed {
    logic [SQ_ARG_W-1:0]  arg;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DV_LOW_W-1:0] low;
    logic [DV_REM_W-1:0] rem;
    logic [DV_Q_W-1:0]   q;
  } dv_t;

  typedef struct packed {
    tag_t tag;
    sq_t  sq;
    dv_t  dv;
  } iter_t;

  typedef struct packed {
    logic [RING_W-1:0] ring;
    region_t           region;
    logic              err;
  } result_t;

  // One step of the restoring square root: brings down two radicand bits.
  function automatic sq_t sqrt_step(sq_t s);
    logic [SQ_TRY_W-1:0] rem_sh;
    logic [SQ_TRY_W-1:0] trial;
    sq_t                 r;
    rem_sh = {s.rem, s.arg[SQ_ARG_W-1 -: 2]};
    trial  = SQ_TRY_W'({s.root, 2'b01});
    r.arg  = {s.arg[SQ_ARG_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = SQ_REM_W'(rem_sh - trial);
      r.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = SQ_REM_W'(rem_sh);
      r.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One step of the restoring division by n: brings down one dividend bit.
  function automatic dv_t div_step(dv_t d, logic [RES_W-1:0] n);
    logic [DV_REM_W:0] rem_sh;
    dv_t               r;
    rem_sh = {d.rem, d.low[DV_LOW_W-1]};
    r.low  = {d.low[DV_LOW_W-2:0], 1'b0};
    if (rem_sh >= {1'b0, n}) begin
      r.rem = DV_REM_W'(rem_sh - {1'b0, n});
      r.q   = {d.q[DV_Q_W-2:0], 1'b1};
    end else begin
      r.rem = DV_REM_W'(rem_sh);
      r.q   = {d.q[DV_Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> design/hrp_channels.sv
// Valid/ready channel interfaces for the pixel input, the ring result and the resolution write.
// Depends on hrp_pkg for field widths.
interface hrp_in_if;
  logic                      valid;
  logic                      ready;
  logic [hrp_pkg::PIX_W-1:0] pixel_index;

  modport source (output valid, output pixel_index, input ready);
  modport sink (input valid, input pixel_index, output ready);
endinterface

interface hrp_out_if;
  logic                       valid;
  logic                       ready;
  logic [hrp_pkg::RING_W-1:0] ring_number;
  logic [hrp_pkg::REG_W-1:0]  region;
  logic                       index_error;

  modport source (output valid, output ring_number, output region, output index_error,
                  input ready);
  modport sink (input valid, input ring_number, input region, input index_error,
                output ready);
endinterface

interface hrp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [hrp_pkg::RES_W-1:0] resolution;

  modport source (output valid, output resolution, input ready);
  modport sink (input valid, input resolution, output ready);
endinterface

>>> design/hrp_front.sv
// Front end: three pipeline stages that square n, form the pixel counts and classify the index.
// Depends on hrp_pkg; feeds the first iteration stage.
module hrp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hrp_pkg::PIX_W-1:0] pixel_index,
  input  logic [hrp_pkg::RES_W-1:0] resolution,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hrp_pkg::iter_t            out_data
);

  logic valid1_r, valid2_r, valid3_r;
  logic ready1, ready2, ready3;

  logic [hrp_pkg::PIX_W-1:0]  p1_r, p2_r;
  logic [hrp_pkg::RES_W-1:0]  n1_r, n2_r;
  logic [hrp_pkg::NN_W-1:0]   nn1_r;
  logic [hrp_pkg::NPIX_W-1:0] npix2_r;
  logic [hrp_pkg::NCAP_W-1:0] ncap2_r;
  hrp_pkg::iter_t             d3_r;

  logic [2*hrp_pkg::RES_W-1:0] nn_full;
  logic [hrp_pkg::NN_W-1:0]    nn_nxt;
  logic [hrp_pkg::NPIX_W-1:0]  npix_nxt;
  logic [hrp_pkg::NCAP_W:0]    ncap_full;
  logic [hrp_pkg::NCAP_W-1:0]  ncap_nxt;
  hrp_pkg::iter_t              d3_nxt;

  logic [hrp_pkg::PIX_W-1:0]   ncap_ext;
  logic [hrp_pkg::PIX_W-1:0]   band_end;
  logic [hrp_pkg::PIX_W-1:0]   south_q;
  logic [hrp_pkg::PIX_W-1:0]   band_off;
  logic [hrp_pkg::SQ_IN_W-1:0] north_arg;
  logic [hrp_pkg::SQ_IN_W-1:0] south_arg;
  logic [hrp_pkg::DV_W-1:0]    dividend;
  logic                        is_err, is_north, is_equator;

  // Full-width square of the resolution.
  function automatic logic [2*hrp_pkg::RES_W-1:0] n1_nxt_mul(logic [hrp_pkg::RES_W-1:0] n);
    return (2*hrp_pkg::RES_W)'(n) * (2*hrp_pkg::RES_W)'(n);
  endfunction

  // Each stage moves on when it is empty or its successor takes its item.
  assign ready3    = !valid3_r || out_ready;
  assign ready2    = !valid2_r || ready3;
  assign ready1    = !valid1_r || ready2;
  assign in_ready  = ready1;
  assign out_valid = valid3_r;
  assign out_data  = d3_r;

  // Stage one: square the resolution.
  assign nn_full = n1_nxt_mul(resolution);
  assign nn_nxt  = nn_full[hrp_pkg::NN_W-1:0];

  // Stage two: total pixel count 12*n*n and polar cap size 2*n*(n-1).
  assign npix_nxt  = {nn1_r, 3'b000} + {1'b0, nn1_r, 2'b00};
  assign ncap_full = {nn1_r, 1'b0} - (hrp_pkg::NCAP_W + 1)'({n1_r, 1'b0});
  assign ncap_nxt  = ncap_full[hrp_pkg::NCAP_W-1:0];

  // Stage three: region decision and operands for the square root and the division.
  always_comb begin
    ncap_ext   = hrp_pkg::PIX_W'(ncap2_r);
    band_end   = npix2_r - ncap_ext;
    south_q    = npix2_r - p2_r;
    band_off   = p2_r - ncap_ext;
    is_err     = (p2_r >= npix2_r);
    is_north   = (p2_r < ncap_ext);
    is_equator = (p2_r < band_end);
    north_arg  = {p2_r[hrp_pkg::SQ_IN_W-2:0], 1'b1};
    south_arg  = {south_q[hrp_pkg::SQ_IN_W-2:0], 1'b0} - hrp_pkg::SQ_IN_W'(1);
    dividend   = band_off[hrp_pkg::PIX_W-1:2];

    d3_nxt.tag.err = is_err;
    d3_nxt.tag.n   = n2_r;
    if (is_err || is_north) begin
      d3_nxt.tag.region = hrp_pkg::REGION_NORTH;
    end else if (is_equator) begin
      d3_nxt.tag.region = hrp_pkg::REGION_EQUATOR;
    end else begin
      d3_nxt.tag.region = hrp_pkg::REGION_SOUTH;
    end

    d3_nxt.sq.arg  = is_north ? hrp_pkg::SQ_ARG_W'(north_arg) : hrp_pkg::SQ_ARG_W'(south_arg);
    d3_nxt.sq.rem  = '0;
    d3_nxt.sq.root = '0;

    d3_nxt.dv.low = dividend[hrp_pkg::DV_LOW_W-1:0];
    d3_nxt.dv.rem = hrp_pkg::DV_REM_W'(dividend[hrp_pkg::DV_W-1:hrp_pkg::DV_LOW_W]);
    d3_nxt.dv.q   = '0;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      if (ready1) valid1_r <= in_valid;
      if (ready2) valid2_r <= valid1_r;
      if (ready3) valid3_r <= valid2_r;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk) begin
    if (ready1) begin
      p1_r  <= pixel_index;
      n1_r  <= resolution;
      nn1_r <= nn_nxt;
    end
    if (ready2) begin
      p2_r    <= p1_r;
      n2_r    <= n1_r;
      npix2_r <= npix_nxt;
      ncap2_r <= ncap_nxt;
    end
    if (ready3) begin
      d3_r <= d3_nxt;
    end
  end

endmodule

>>> design/hrp_iter_stage.sv
// One slice of the iteration pipeline: two square-root steps and two division steps per item.
// Depends on hrp_pkg for the step functions and the item type.
module hrp_iter_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hrp_pkg::iter_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hrp_pkg::iter_t out_data
);

  logic           valid_r;
  hrp_pkg::iter_t d_r;
  hrp_pkg::iter_t d_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = d_r;

  // Both recurrences run on every item; the back end picks the one its region needs.
  always_comb begin
    d_nxt = in_data;
    for (int i = 0; i < hrp_pkg::STEPS_PER_STAGE; i++) begin
      d_nxt.sq = hrp_pkg::sqrt_step(d_nxt.sq);
      d_nxt.dv = hrp_pkg::div_step(d_nxt.dv, d_nxt.tag.n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> design/hrp_back.sv
// Back end: turns the root or quotient into a ring number and holds results in an output skid.
// Depends on hrp_pkg and on the hrp_out_if channel interface.
module hrp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hrp_pkg::iter_t   in_data,
  hrp_out_if.source        out_ch
);

  logic              out_valid_r, skid_valid_r;
  hrp_pkg::result_t  out_r, skid_r;
  hrp_pkg::result_t  res_nxt;

  logic [hrp_pkg::SQ_ROOT_W:0]    half_sum;
  logic [hrp_pkg::SQ_ROOT_W-1:0]  half;
  logic [hrp_pkg::RING_SUM_W-1:0] ring_wide;
  logic                           accept, take;

  // Ring number from the iteration results.
  always_comb begin
    half_sum = {1'b0, in_data.sq.root} + (hrp_pkg::SQ_ROOT_W + 1)'(1);
    half     = half_sum[hrp_pkg::SQ_ROOT_W:1];
    case (in_data.tag.region)
      hrp_pkg::REGION_EQUATOR:
        ring_wide = hrp_pkg::RING_SUM_W'(in_data.dv.q) + hrp_pkg::RING_SUM_W'(in_data.tag.n);
      hrp_pkg::REGION_SOUTH:
        ring_wide = hrp_pkg::RING_SUM_W'({in_data.tag.n, 2'b00}) - hrp_pkg::RING_SUM_W'(half);
      default:
        ring_wide = hrp_pkg::RING_SUM_W'(half);
    endcase
    res_nxt.err    = in_data.tag.err;
    res_nxt.region = in_data.tag.err ? hrp_pkg::REGION_NORTH : in_data.tag.region;
    res_nxt.ring   = in_data.tag.err ? '0 : ring_wide[hrp_pkg::RING_W-1:0];
  end

  // The upstream side sees only the registered skid flag.
  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign take     = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ring_number = out_r.ring;
  assign out_ch.region      = out_r.region;
  assign out_ch.index_error = out_r.err;

  // The skid register only fills behind a result that is being held.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  // An item arriving while the output is held must land in the skid register.
  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && accept) |=> skid_valid_r)
    else $error("item arrived during a stall but was not caught by the skid");

endmodule

>>> design/healpix_ring_of_pixel.sv
// Top level of the HEALPix ring-number pipeline: resolution register, front end,
// iteration slices and output back end. Depends on hrp_pkg and the channel interfaces.

// The block takes one ring-scheme pixel index per cycle while the output is not stalled
// and returns its ring number, region and an error flag, in order, through three front-end
// stages (squaring n, pixel counts, region decision), eight iteration slices that each
// retire two bits of the square root and of the quotient by n, and one output register
// with a skid entry behind it. The iteration slices perform sixteen restoring steps,
// two per stage, for both recurrences. A resolution write takes effect for items that
// transfer in after it; values above 8192 are held at 8192, and a resolution of zero
// marks every index as an error. No clearing pass is needed after reset.
module healpix_ring_of_pixel (
  input  logic      clk,
  input  logic      rst_n,
  hrp_in_if.sink    in_ch,
  hrp_out_if.source out_ch,
  hrp_cfg_if.sink   cfg_ch
);

  logic [hrp_pkg::RES_W-1:0] resolution_r;
  logic [hrp_pkg::RES_W-1:0] resolution_nxt;

  logic           valid_w [hrp_pkg::ITER_STAGES+1];
  logic           ready_w [hrp_pkg::ITER_STAGES+1];
  hrp_pkg::iter_t data_w  [hrp_pkg::ITER_STAGES+1];

  // Resolution register, saturated at the largest supported nside.
  assign cfg_ch.ready   = 1'b1;
  assign resolution_nxt = (cfg_ch.resolution > hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION)) ?
                          hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION) : cfg_ch.resolution;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= hrp_pkg::RES_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      resolution_r <= resolution_nxt;
    end
  end

  // Front end.
  hrp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .pixel_index (in_ch.pixel_index),
    .resolution  (resolution_r),
    .out_valid   (valid_w[0]),
    .out_ready   (ready_w[0]),
    .out_data    (data_w[0])
  );

  // Iteration slices.
  for (genvar g = 0; g < hrp_pkg::ITER_STAGES; g++) begin : g_iter
    hrp_iter_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_w[g]),
      .in_ready  (ready_w[g]),
      .in_data   (data_w[g]),
      .out_valid (valid_w[g+1]),
      .out_ready (ready_w[g+1]),
      .out_data  (data_w[g+1])
    );
  end

  // Ring formation and output skid.
  hrp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (valid_w[hrp_pkg::ITER_STAGES]),
    .in_ready (ready_w[hrp_pkg::ITER_STAGES]),
    .in_data  (data_w[hrp_pkg::ITER_STAGES]),
    .out_ch   (out_ch)
  );

  // An error result carries ring zero in the north-cap code.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.index_error) |->
      (out_ch.ring_number == '0 && out_ch.region == hrp_pkg::REGION_NORTH))
    else $error("error result with non-zero ring or region");

  // A valid pixel always lies on a ring numbered from one.
  a_ring_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.index_error) |-> (out_ch.ring_number != '0))
    else $error("in-range pixel produced ring zero");

endmodule

>>> sim/hrp_ring_checker.sv
// Checker for the HEALPix ring-number block: watches the pixel, result and resolution channels,
// predicts each result and compares it with what the block returns.
// Depends on hrp_pkg and the channel interfaces in the design folder.
module hrp_ring_checker (
  input  logic clk,
  input  logic rst_n,
  hrp_in_if    in_ch,
  hrp_out_if   out_ch,
  hrp_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   north_seen,
  output int   equator_seen,
  output int   south_seen,
  output int   error_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the resolution register and the results still owed by the block.
  logic [hrp_pkg::RES_W-1:0] nside_copy;
  hrp_pkg::result_t          ring_queue [$];

  // Largest r with r*r <= v, found one root bit at a time from the top.
  function automatic logic [15:0] floor_root(input logic [31:0] v);
    logic [15:0] r;
    logic [15:0] cand;
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      cand = r | (16'd1 << k);
      if (64'(cand) * 64'(cand) <= 64'(v)) begin
        r = cand;
      end
    end
    return r;
  endfunction

  // Written resolutions above the maximum are held at the maximum.
  function automatic logic [hrp_pkg::RES_W-1:0] clamp_nside(
      input logic [hrp_pkg::RES_W-1:0] v);
    return (v > hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION)) ?
           hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION) : v;
  endfunction

  // Ring number, region and error flag of one pixel at resolution n.
  function automatic hrp_pkg::result_t ring_of_pixel(input logic [hrp_pkg::PIX_W-1:0] pix,
                                                     input logic [hrp_pkg::RES_W-1:0] n);
    logic [31:0]      n32;
    logic [31:0]      npix;
    logic [31:0]      ncap;
    logic [31:0]      p32;
    logic [31:0]      q;
    hrp_pkg::result_t r;
    n32      = 32'(n);
    npix     = 32'd12 * n32 * n32;
    ncap     = 32'd2 * n32 * n32 - 32'd2 * n32;
    p32      = 32'(pix);
    r.ring   = '0;
    r.region = hrp_pkg::REGION_NORTH;
    r.err    = 1'b0;
    if (p32 >= npix) begin
      r.err = 1'b1;
    end else if (p32 < ncap) begin
      r.region = hrp_pkg::REGION_NORTH;
      r.ring   = hrp_pkg::RING_W'((32'd1 + 32'(floor_root(32'd2 * p32 + 32'd1))) >> 1);
    end else if (p32 < npix - ncap) begin
      r.region = hrp_pkg::REGION_EQUATOR;
      r.ring   = hrp_pkg::RING_W'((p32 - ncap) / (32'd4 * n32) + n32);
    end else begin
      q        = npix - p32;
      r.region = hrp_pkg::REGION_SOUTH;
      r.ring   = hrp_pkg::RING_W'(32'd4 * n32 -
                                  ((32'd1 + 32'(floor_root(32'd2 * q - 32'd1))) >> 1));
    end
    return r;
  endfunction

  // Track register writes, queue a prediction per input transfer, check each result transfer.
  always @(posedge clk) begin
    hrp_pkg::result_t want;
    if (!rst_n) begin
      nside_copy   = hrp_pkg::RES_W'(1);
      ring_queue.delete();
      fail_count   = 0;
      north_seen   = 0;
      equator_seen = 0;
      south_seen   = 0;
      error_seen   = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        nside_copy = clamp_nside(cfg_ch.resolution);
      end
      if (in_ch.valid && in_ch.ready) begin
        ring_queue.insert(ring_queue.size(), ring_of_pixel(in_ch.pixel_index, nside_copy));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (ring_queue.size() == 0) begin
          $display("%0t: result transfer with nothing expected (ring %0d region %0d err %0b)",
                   $time, out_ch.ring_number, out_ch.region, out_ch.index_error);
          fail_count++;
        end else begin
          want = ring_queue.pop_front();
          if (out_ch.ring_number !== want.ring) begin
            $display("%0t: ring_number expected %0d, actual %0d", $time, want.ring,
                     out_ch.ring_number);
            fail_count++;
          end
          if (out_ch.region !== want.region) begin
            $display("%0t: region expected %0d, actual %0d", $time, want.region,
                     out_ch.region);
            fail_count++;
          end
          if (out_ch.index_error !== want.err) begin
            $display("%0t: index_error expected %0b, actual %0b", $time, want.err,
                     out_ch.index_error);
            fail_count++;
          end
          if (want.err) begin
            error_seen++;
          end else if (want.region == hrp_pkg::REGION_NORTH) begin
            north_seen++;
          end else if (want.region == hrp_pkg::REGION_EQUATOR) begin
            equator_seen++;
          end else begin
            south_seen++;
          end
        end
      end
    end
    pending = ring_queue.size();
  end

endmodule

>>> sim/tb.sv
// Top of the HEALPix ring-number testbench: clock, reset, pixel and resolution stimulus,
// the output-side stall pattern and the final verdict. Depends on hrp_pkg, the channel
// interfaces, the block itself and hrp_ring_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 155;
  localparam int LONG_HOLD     = 150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Shared between the sender and the receiver process.
  bit no_idle       = 1'b0;
  bit long_hold_req = 1'b0;

  int fail_count;
  int pending;
  int north_seen;
  int equator_seen;
  int south_seen;
  int error_seen;
  int cycle_count = 0;
  int settings_written = 0;

  hrp_in_if  in_ch ();
  hrp_out_if out_ch ();
  hrp_cfg_if cfg_ch ();

  healpix_ring_of_pixel DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  hrp_ring_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .north_seen   (north_seen),
    .equator_seen (equator_seen),
    .south_seen   (south_seen),
    .error_seen   (error_seen)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("** healpix_ring_of_pixel: FAILED **");
      $finish;
    end
  end

  // Offer one pixel after a random gap and hold it until the transfer.
  task automatic send_pixel(input logic [hrp_pkg::PIX_W-1:0] pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.pixel_index <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has been transferred.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One resolution write; the block is idle whenever this is called.
  task automatic write_resolution(input logic [hrp_pkg::RES_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.resolution <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_written++;
  endtask

  // Pixel drawn mostly inside the valid range, spread over the three regions,
  // with boundary values and the odd fully random index.
  function automatic logic [hrp_pkg::PIX_W-1:0] random_pixel(
      input logic [hrp_pkg::RES_W-1:0] n);
    logic [31:0] n32;
    logic [31:0] npix;
    logic [31:0] ncap;
    logic [31:0] pick;
    int unsigned sel;
    n32  = 32'(n);
    npix = 32'd12 * n32 * n32;
    ncap = 32'd2 * n32 * n32 - 32'd2 * n32;
    sel  = $urandom_range(0, 99);
    if (n32 == 0) begin
      pick = $urandom;
    end else if (sel < 28 && ncap > 0) begin
      pick = $urandom_range(ncap - 1, 0);
    end else if (sel < 58) begin
      pick = $urandom_range(npix - ncap - 1, ncap);
    end else if (sel < 86 && ncap > 0) begin
      pick = $urandom_range(npix - 1, npix - ncap);
    end else if (sel < 95) begin
      case ($urandom_range(0, 5))
        0: pick = ncap - 1;
        1: pick = ncap;
        2: pick = npix - ncap - 1;
        3: pick = npix - ncap;
        4: pick = npix - 1;
        default: pick = npix;
      endcase
    end else begin
      pick = $urandom;
    end
    return pick[hrp_pkg::PIX_W-1:0];
  endfunction

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Sender: reset, directed pixels, then random phases over a range of resolutions.
  initial begin
    logic [hrp_pkg::RES_W-1:0] res_plan [PHASES];
    logic [hrp_pkg::RES_W-1:0] eff_n;
    in_ch.valid       = 1'b0;
    in_ch.pixel_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.resolution = '0;

    res_plan[0]  = hrp_pkg::RES_W'(1);
    res_plan[1]  = hrp_pkg::RES_W'(2);
    res_plan[2]  = hrp_pkg::RES_W'(3);
    res_plan[3]  = hrp_pkg::RES_W'($urandom_range(15, 4));
    res_plan[4]  = hrp_pkg::RES_W'($urandom_range(127, 16));
    res_plan[5]  = hrp_pkg::RES_W'($urandom_range(1023, 128));
    res_plan[6]  = hrp_pkg::RES_W'($urandom_range(8191, 1024));
    res_plan[7]  = hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION);
    res_plan[8]  = hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION - 1);
    res_plan[9]  = hrp_pkg::RES_W'(0);
    res_plan[10] = hrp_pkg::RES_W'($urandom_range(16383, hrp_pkg::MAX_RESOLUTION + 1));
    res_plan[11] = hrp_pkg::RES_W'(16383);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset resolution of one: three of the twelve base pixels and indices past the end.
    send_pixel(30'd0);
    send_pixel(30'd5);
    send_pixel(30'd11);
    send_pixel(30'd12);
    send_pixel(30'h3FFF_FFFF);

    // Small resolution: both cap boundaries and the first index past the end.
    settle();
    write_resolution(hrp_pkg::RES_W'(4));
    send_pixel(30'd0);
    send_pixel(30'd1);
    send_pixel(30'd23);
    send_pixel(30'd24);
    send_pixel(30'd167);
    send_pixel(30'd168);
    send_pixel(30'd191);
    send_pixel(30'd192);

    // Largest resolution: region boundaries and the top of the index range.
    settle();
    write_resolution(hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION));
    send_pixel(30'd0);
    send_pixel(30'd134201343);
    send_pixel(30'd134201344);
    send_pixel(30'd671105023);
    send_pixel(30'd671105024);
    send_pixel(30'd805306367);
    send_pixel(30'd805306368);
    send_pixel(30'h3FFF_FFFF);

    // Resolution zero makes every index an error.
    settle();
    write_resolution(hrp_pkg::RES_W'(0));
    send_pixel(30'd0);
    send_pixel(30'd1);

    // A write above the maximum is held at the maximum.
    settle();
    write_resolution(hrp_pkg::RES_W'(16383));
    send_pixel(30'd805306367);
    send_pixel(30'd805306368);

    // Random phases. Phase four stalls the output for a long stretch while the
    // input keeps pushing; phases four and five run without idle cycles; phase
    // six pauses half way until the block has drained.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_resolution(res_plan[ph]);
      eff_n   = (res_plan[ph] > hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION)) ?
                hrp_pkg::RES_W'(hrp_pkg::MAX_RESOLUTION) : res_plan[ph];
      no_idle = (ph == 4 || ph == 5);
      if (ph == 4) begin
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 6 && i == PHASE_ITEMS / 2) begin
          settle();
        end
        send_pixel(random_pixel(eff_n));
      end
    end
    no_idle = 1'b0;

    // Drain and let the pipeline run empty before the verdict.
    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display({"Checked %0d results over %0d resolution writes: ",
              "north %0d, equator %0d, south %0d, index errors %0d."},
             north_seen + equator_seen + south_seen + error_seen, settings_written,
             north_seen, equator_seen, south_seen, error_seen);
    $display({"Resolutions ran from zero through saturated writes, ",
              "with a long output stall and a mid-run drain."});
    if (fail_count == 0) begin
      $display("** healpix_ring_of_pixel: PASSED **");
    end else begin
      $display("** healpix_ring_of_pixel: FAILED **");
    end
    $finish;
  end

endmodule
